FILE: sv/ntc_pkg.sv
`timescale 1ns / 1ps
// Package for the NTC thermistor table interpolator.
// Holds the code table, field widths, fixed constants and the state type.
package ntc_pkg;

  // Field widths
  localparam int CODE_W = 12;
  localparam int TEMP_W = 12;

  // Table geometry
  localparam int ROM_SIZE      = 42;
  localparam int TABLE_ENTRIES = 42;
  localparam int ENTRY_N = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                           (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
  // Width of an entry count (0..ENTRY_N); also the number of search steps
  localparam int CNT_W = $clog2(ENTRY_N + 1);

  // Temperature scale in tenths of a degree
  localparam int COLD_TENTHS = -550;
  localparam int STEP_TENTHS = 50;
  localparam int HOT_TENTHS  = COLD_TENTHS + STEP_TENTHS * (ENTRY_N - 1);

  // Divider: quotient is always below STEP_TENTHS
  localparam int QUO_W = $clog2(STEP_TENTHS);
  localparam int NUM_W = CODE_W + QUO_W;

  // Descending converter codes, one every 5 degrees from -55 C
  localparam logic [CODE_W-1:0] NTC_ROM [ROM_SIZE] = '{
    12'd4086, 12'd4084, 12'd4082, 12'd4079, 12'd4075, 12'd4069, 12'd4062,
    12'd4052, 12'd4040, 12'd4023, 12'd4002, 12'd3976, 12'd3942, 12'd3901,
    12'd3851, 12'd3790, 12'd3717, 12'd3632, 12'd3533, 12'd3421, 12'd3295,
    12'd3155, 12'd3004, 12'd2843, 12'd2674, 12'd2500, 12'd2323, 12'd2147,
    12'd1974, 12'd1807, 12'd1647, 12'd1495, 12'd1354, 12'd1223, 12'd1102,
    12'd992,  12'd892,  12'd802,  12'd721,  12'd647,  12'd582,  12'd524
  };

  // Table read; entries past the end read as zero so the table stays
  // non-increasing over the whole search space
  function automatic logic [CODE_W-1:0] ntc_entry(input logic [CNT_W-1:0] idx);
    logic [CODE_W-1:0] val;
    val = '0;
    if (int'(idx) < ENTRY_N) begin
      val = NTC_ROM[idx];
    end
    return val;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SETUP,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } ntc_state_t;

endpackage

FILE: sv/ntc_table_interpolator_core.sv
`timescale 1ns / 1ps
// NTC thermistor code to temperature converter, top level.
// Depends on ntc_pkg for the code table, widths and state type.

// Converts one 12-bit converter code into temperature in tenths of a degree
// Celsius, clamped to -550 at the cold end and 1500 at the hot end. One word
// is worked on at a time and passes through these steps before the result is
// offered: 6 binary search steps over the code table (one index bit per
// cycle), a segment setup step, 6 steps of the restoring divider (one
// quotient bit per cycle), a rounding step and an output load. Clamped
// codes skip the divider and rounding. The result sits in an output register,
// so a new word is taken while the previous result waits; a second finished
// result stalls the input until the first one is taken.
module ntc_table_interpolator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ntc_pkg::CODE_W-1:0]        adc_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0] temp_tenths
);
  import ntc_pkg::*;

  ntc_state_t state, state_next;

  logic [CODE_W-1:0]        code;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         stepbit;
  logic [NUM_W-1:0]         rem;
  logic [NUM_W-1:0]         dsr;
  logic [QUO_W-1:0]         quo;
  logic [QUO_W-1:0]         qbit;
  logic signed [TEMP_W-1:0] base;
  logic signed [TEMP_W-1:0] res;

  // Search probe: last index of the candidate block
  logic [CNT_W-1:0]  probe;
  logic              probe_hit;
  // Segment setup
  logic [CNT_W-1:0]  seg;
  logic [CODE_W-1:0] hi;
  logic [CODE_W-1:0] lo;
  logic [CODE_W-1:0] wdt;
  logic [CODE_W-1:0] delta;
  logic              is_cold;
  logic              is_hot;
  // Divider step
  logic              take;
  logic              rnd;
  logic              out_free;

  assign probe     = pos | (stepbit - CNT_W'(1));
  assign probe_hit = (ntc_entry(probe) >= code);

  assign seg     = pos - CNT_W'(1);
  assign hi      = ntc_entry(seg);
  assign lo      = ntc_entry(pos);
  assign wdt     = hi - lo;
  assign delta   = hi - code;
  assign is_cold = (pos == '0);
  assign is_hot  = (int'(pos) >= ENTRY_N);

  assign take     = (rem >= dsr);
  assign rnd      = base[TEMP_W-1] && (rem != '0);
  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stepbit[0]) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (is_cold || is_hot) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (qbit[0]) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath: search, setup, divider, rounding
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        code    <= adc_code;
        pos     <= '0;
        stepbit <= {1'b1, {(CNT_W-1){1'b0}}};
      end
      ST_SEARCH: begin
        if (probe_hit) begin
          pos <= pos | stepbit;
        end
        stepbit <= stepbit >> 1;
      end
      ST_SETUP: begin
        base <= TEMP_W'(STEP_TENTHS * int'(seg) + COLD_TENTHS);
        rem  <= NUM_W'(delta) * NUM_W'(STEP_TENTHS);
        dsr  <= NUM_W'(wdt) << (QUO_W - 1);
        quo  <= '0;
        qbit <= {1'b1, {(QUO_W-1){1'b0}}};
        if (is_cold) begin
          res <= TEMP_W'(COLD_TENTHS);
        end else if (is_hot) begin
          res <= TEMP_W'(HOT_TENTHS);
        end
      end
      ST_DIV: begin
        if (take) begin
          rem <= rem - dsr;
        end
        quo  <= {quo[QUO_W-2:0], take};
        dsr  <= dsr >> 1;
        qbit <= qbit >> 1;
      end
      ST_ROUND: begin
        // truncation toward zero lifts a negative inexact result by one
        res <= base + TEMP_W'(quo) + TEMP_W'(rnd);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      temp_tenths <= res;
    end
  end

  // Checks
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_tenths >= TEMP_W'(COLD_TENTHS)) &&
                  (temp_tenths <= TEMP_W'(HOT_TENTHS)))
    else $error("temperature out of range");

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> $onehot(stepbit))
    else $error("search step not one-hot");

  a_segment: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETUP && !is_cold && !is_hot) |-> (hi >= code) && (lo < code))
    else $error("search found wrong segment");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < {dsr, 1'b0}))
    else $error("divider remainder overflow");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SEARCH) && !in_ready)
    else $error("accepted word did not start search");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ntc_table_interpolator_core.
// Depends on ntc_pkg for port widths; predicts each temperature from its own code table.
module testbench;

  localparam int CODE_W     = ntc_pkg::CODE_W;
  localparam int TEMP_W     = ntc_pkg::TEMP_W;
  localparam int N_ENTRIES  = 42;
  localparam int COLD_T     = -550;
  localparam int STEP_T     = 50;
  localparam int HOT_T      = COLD_T + STEP_T * (N_ENTRIES - 1);
  localparam int RANDOM_N   = 800;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE_CYC = 24;
  localparam int MAX_PRINTS = 30;

  // Converter codes, descending, one every 5 degrees from -55 C
  localparam int CODE_TABLE [N_ENTRIES] = '{
    4086, 4084, 4082, 4079, 4075, 4069, 4062, 4052, 4040, 4023,
    4002, 3976, 3942, 3901, 3851, 3790, 3717, 3632, 3533, 3421,
    3295, 3155, 3004, 2843, 2674, 2500, 2323, 2147, 1974, 1807,
    1647, 1495, 1354, 1223, 1102,  992,  892,  802,  721,  647,
     582,  524
  };

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [CODE_W-1:0]        adc_code;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [TEMP_W-1:0] temp_tenths;

  logic signed [TEMP_W-1:0] temp_expected_q [$];
  logic signed [TEMP_W-1:0] temp_due;
  int                       error_count;
  int                       codes_sent;
  int                       temps_checked;
  int                       burst_left;
  bit                       gaps_off;
  bit                       hold_off_req;

  ntc_table_interpolator_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_code    (adc_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .temp_tenths (temp_tenths)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Temperature predicted for one code: clamp at both ends, else linear
  // interpolation in the segment holding the code, truncated toward zero
  function automatic logic signed [TEMP_W-1:0] temp_for_code(input logic [CODE_W-1:0] code);
    int  c;
    int  seg_w;
    int  t;
    bit  found;
    c     = int'(code);
    t     = HOT_T;
    found = 1'b0;
    if (c > CODE_TABLE[0]) begin
      t = COLD_T;
    end else if (c > CODE_TABLE[N_ENTRIES-1]) begin
      for (int i = 0; i < N_ENTRIES - 1; i++) begin
        if (!found && c <= CODE_TABLE[i] && c > CODE_TABLE[i+1]) begin
          seg_w = CODE_TABLE[i] - CODE_TABLE[i+1];
          t     = ((STEP_T * i + COLD_T) * seg_w + STEP_T * (CODE_TABLE[i] - c)) / seg_w;
          found = 1'b1;
        end
      end
    end
    return t[TEMP_W-1:0];
  endfunction

  // One line per mismatch, counted; printing capped to keep the log short
  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Offer one code word, hold it until taken, then maybe pause between bursts
  task automatic send_code(input logic [CODE_W-1:0] code);
    int gap;
    in_valid <= 1'b1;
    adc_code <= code;
    // ready only moves at rising edges, so look at it mid-cycle
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    temp_expected_q.push_back(temp_for_code(code));
    codes_sent++;
    if (!gaps_off) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 20);
        if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(30, 80);
        else burst_left = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering and wait for every outstanding temperature
  task automatic drain;
    in_valid <= 1'b0;
    while (temp_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Clamps, table edges and bit patterns
  task automatic test_directed;
    logic [CODE_W-1:0] codes [$];
    codes = '{12'd4095, 12'd4087, 12'd4086, 12'd4085, 12'd4084, 12'd4083,
              12'd4000, 12'd3000, 12'd2048, 12'd1500, 12'd583,  12'd582,
              12'd581,  12'd525,  12'd524,  12'd523,  12'd1,    12'd0,
              12'hAAA,  12'h555,  12'd4062, 12'd1102, 12'd2500};
    foreach (codes[k]) send_code(codes[k]);
    drain();
  endtask

  // Mixed random codes: full range, around table entries, dense cold end
  task automatic test_random_traffic;
    int sel;
    int code;
    for (int k = 0; k < RANDOM_N; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        code = $urandom_range(0, 4095);
      end else if (sel < 8) begin
        code = CODE_TABLE[$urandom_range(0, N_ENTRIES-1)] + $urandom_range(0, 2) - 1;
      end else begin
        code = $urandom_range(4060, 4095);
      end
      send_code(code[CODE_W-1:0]);
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_back_pressure;
    gaps_off     = 1'b1;
    hold_off_req = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_code(CODE_W'($urandom_range(0, 4095)));
    end
    gaps_off = 1'b0;
    drain();
  endtask

  // Receiver: stall pattern picked anew at random from time to time, long hold on request
  initial begin : rx_pattern
    int cyc;
    int mode;
    out_ready = 1'b0;
    cyc       = 0;
    mode      = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready   <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        cyc++;
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (cyc % 8 == 7);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check every accepted temperature against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (temp_expected_q.size() == 0) begin
        report_mismatch("unexpected temperature word", temp_tenths, 0);
      end else begin
        temp_due = temp_expected_q.pop_front();
        temps_checked++;
        if (temp_tenths !== temp_due) begin
          report_mismatch("temp_tenths", temp_tenths, temp_due);
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    adc_code      = '0;
    error_count   = 0;
    codes_sent    = 0;
    temps_checked = 0;
    burst_left    = 0;
    gaps_off      = 1'b0;
    hold_off_req  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_back_pressure();

    $display("Converted %0d codes, %0d temperatures checked, covering both clamps,",
             codes_sent, temps_checked);
    $display("every table segment edge, random stalls and a %0d-cycle receiver hold.",
             LONG_HOLD);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d temperatures outstanding", temp_expected_q.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ntc_pkg.sv
sv/ntc_table_interpolator_core.sv
tb/sv/testbench.sv
